// File: sv/wss_pkg.sv
package wss_pkg;

   // Fraction bits of the Q16.16 values
   localparam int unsigned FRAC_BITS = 16;

   // Shared divider: 48-bit dividend (32-bit magnitude over 16 fraction bits)
   localparam int unsigned DIV_STEPS = 48;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int unsigned DIV_DVD_W = 48;
   localparam int unsigned DIV_DSR_W = 31;

   // Register values after reset
   localparam logic [30:0] RELAX_RESET  = 31'd3276800;
   localparam logic [30:0] TRAVEL_RESET = 31'd655360;
   localparam logic [30:0] RADIUS_RESET = 31'd2293760;
   localparam logic [30:0] MASS_RESET   = 31'd1310720;
   localparam logic [30:0] DAMP_RESET   = 31'd65536;
   localparam logic [30:0] STIFF_RESET  = 31'd65536;

   // Saturation limits of the signed Q16.16 range
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_RELAX  = 3'd0,
      CSR_TRAVEL = 3'd1,
      CSR_RADIUS = 3'd2,
      CSR_MASS   = 3'd3,
      CSR_DAMP   = 3'd4,
      CSR_STIFF  = 3'd5
   } csr_index_type;

   // Operand pairs of the shared multiplier
   typedef enum logic [2:0] {
      MUL_ACCEL = 3'd0,
      MUL_T1    = 3'd1,
      MUL_SPEED = 3'd2,
      MUL_DAMP  = 3'd3,
      MUL_STIFF = 3'd4
   } mul_sel_type;

   // Operand pairs of the shared divider
   typedef enum logic {
      DIV_ACCEL = 1'b0,
      DIV_SPEED = 1'b1
   } div_sel_type;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic        load_in;
      logic        limit;
      logic        ground;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        div_start;
      div_sel_type div_sel;
      logic        accel_latch;
      logic        t1_scale;
      logic        t1_half;
      logic        t2_scale;
      logic        move_sum;
      logic        move_clamp;
      logic        speed_latch;
      logic        length_update;
      logic        damp_scale;
      logic        stiff_scale;
      logic        force_sum;
      logic        out_load;
   } cmd_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic free;
      logic div_done;
   } status_type;

endpackage

// File: sv/wss_div.sv
// Unsigned restoring divider, one quotient bit per cycle
module wss_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [wss_pkg::DIV_DVD_W-1:0]   dividend,
   input  logic [wss_pkg::DIV_DSR_W-1:0]   divisor,
   output logic                            done,
   output logic [wss_pkg::DIV_DVD_W-1:0]   quotient
);

   localparam int unsigned DW = wss_pkg::DIV_DVD_W;
   localparam int unsigned SW = wss_pkg::DIV_DSR_W;
   localparam int unsigned CW = wss_pkg::DIV_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] dsr_ff, dsr_in;
   logic [SW:0]   rem_shift;
   logic          fits;

   // Shift in the next dividend bit and trial-subtract the divisor
   assign rem_shift = {rem_ff, quo_ff[DW-1]};
   assign fits      = (rem_shift >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      priority if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-2:0], fits};
         rem_in = fits ? SW'(rem_shift - {1'b0, dsr_ff}) : rem_shift[SW-1:0];
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(wss_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/wss_dpath.sv
// Suspension datapath: registers, shared multiplier, shared divider, saturation
module wss_dpath (
   input  logic                clock,
   input  logic                reset,
   input  wss_pkg::cmd_type    cmd,
   output wss_pkg::status_type status,
   input  logic [15:0]         time_step,
   input  logic                any_hit,
   input  logic [30:0]         hit_distance,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [30:0]         csr_data,
   output logic [95:0]         rsp_tdata,
   output logic                rsp_tuser
);

   // Clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         return wss_pkg::Q_MAX;
      end else if (v < 64'shFFFF_FFFF_8000_0000) begin
         return wss_pkg::Q_MIN;
      end
      return v[31:0];
   endfunction

   // Arithmetic right shift that truncates toward zero
   function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v,
                                                 input logic [5:0] sh);
      logic signed [63:0] bias;
      bias = (64'sd1 <<< sh) - 64'sd1;
      if (v[63]) begin
         return (v + bias) >>> sh;
      end
      return v >>> sh;
   endfunction

   function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   // Apply sign to a quotient magnitude and clamp
   function automatic logic signed [31:0] sign_sat(input logic [47:0] q, input logic neg);
      if (neg) begin
         if (q > 48'h0000_8000_0000) begin
            return wss_pkg::Q_MIN;
         end
         return -q[31:0];
      end
      if (q > 48'h0000_7FFF_FFFF) begin
         return wss_pkg::Q_MAX;
      end
      return q[31:0];
   endfunction

   localparam logic [5:0] SH_Q  = 6'(wss_pkg::FRAC_BITS);
   localparam logic [5:0] SH_Q2 = 6'(wss_pkg::FRAC_BITS + 1);

   // Configuration registers
   logic [30:0] relax_ff, relax_in;
   logic [30:0] travel_ff, travel_in;
   logic [30:0] radius_ff, radius_in;
   logic [30:0] mass_ff, mass_in;
   logic [30:0] damp_ff, damp_in;
   logic [30:0] stiff_ff, stiff_in;

   // Suspension state
   logic signed [31:0] cur_ff, cur_in;
   logic signed [31:0] speed_ff, speed_in;
   logic signed [31:0] force_ff, force_in;

   // Item and working registers
   logic [15:0]        dt_ff, dt_in;
   logic               hit_ff, hit_in;
   logic [30:0]        hd_ff, hd_in;
   logic signed [31:0] max_ff, max_in;
   logic signed [31:0] min_ff, min_in;
   logic               free_ff, free_in;
   logic signed [31:0] accel_ff, accel_in;
   logic signed [31:0] t1_ff, t1_in;
   logic signed [31:0] t2_ff, t2_in;
   logic signed [31:0] move_ff, move_in;
   logic signed [31:0] dforce_ff, dforce_in;
   logic signed [31:0] sforce_ff, sforce_in;
   logic signed [31:0] diff_ff, diff_in;
   logic signed [63:0] prod_ff, prod_in;

   // Result register
   logic signed [31:0] o_motion_ff, o_motion_in;
   logic signed [31:0] o_force_ff, o_force_in;
   logic signed [31:0] o_length_ff, o_length_in;
   logic               o_contact_ff, o_contact_in;

   logic signed [63:0] lim_hi, lim_lo;
   logic signed [31:0] gnd, max_fin;
   logic signed [31:0] mul_a, mul_b;
   logic [31:0]        force_mag, move_mag;
   logic [47:0]        div_dividend;
   logic [30:0]        div_divisor;
   logic               div_done;
   logic [47:0]        div_quotient;

   // Travel limits around rest length
   assign lim_hi = signed'({33'd0, relax_ff}) + signed'({33'd0, travel_ff}) - sx64(cur_ff);
   assign lim_lo = signed'({33'd0, relax_ff}) - signed'({33'd0, travel_ff}) - sx64(cur_ff);

   // Ground limit
   assign gnd     = signed'({1'b0, hd_ff}) - signed'({1'b0, radius_ff});
   assign max_fin = hit_ff ? ((gnd > min_ff) ? gnd : min_ff) : max_ff;

   // Shared multiplier operands
   always_comb begin
      unique case (cmd.mul_sel)
         wss_pkg::MUL_ACCEL: begin
            mul_a = accel_ff;
            mul_b = signed'({16'd0, dt_ff});
         end
         wss_pkg::MUL_T1: begin
            mul_a = t1_ff;
            mul_b = signed'({16'd0, dt_ff});
         end
         wss_pkg::MUL_SPEED: begin
            mul_a = speed_ff;
            mul_b = signed'({16'd0, dt_ff});
         end
         wss_pkg::MUL_DAMP: begin
            mul_a = move_ff;
            mul_b = signed'({1'b0, damp_ff});
         end
         wss_pkg::MUL_STIFF: begin
            mul_a = diff_ff;
            mul_b = signed'({1'b0, stiff_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Divider operands: magnitude over the fraction bits
   assign force_mag = force_ff[31] ? unsigned'(-force_ff) : unsigned'(force_ff);
   assign move_mag  = move_ff[31] ? unsigned'(-move_ff) : unsigned'(move_ff);

   always_comb begin
      unique case (cmd.div_sel)
         wss_pkg::DIV_ACCEL: begin
            div_dividend = {force_mag, 16'd0};
            div_divisor  = mass_ff;
         end
         wss_pkg::DIV_SPEED: begin
            div_dividend = {move_mag, 16'd0};
            div_divisor  = {15'd0, dt_ff};
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   wss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Configuration writes
   always_comb begin
      relax_in  = relax_ff;
      travel_in = travel_ff;
      radius_in = radius_ff;
      mass_in   = mass_ff;
      damp_in   = damp_ff;
      stiff_in  = stiff_ff;
      if (csr_we) begin
         unique case (wss_pkg::csr_index_type'(csr_index))
            wss_pkg::CSR_RELAX:  relax_in  = csr_data;
            wss_pkg::CSR_TRAVEL: travel_in = csr_data;
            wss_pkg::CSR_RADIUS: radius_in = csr_data;
            wss_pkg::CSR_MASS:   mass_in   = csr_data;
            wss_pkg::CSR_DAMP:   damp_in   = csr_data;
            wss_pkg::CSR_STIFF:  stiff_in  = csr_data;
            default: ;
         endcase
      end
   end

   // Step arithmetic, one command at a time
   always_comb begin
      cur_in       = cur_ff;
      speed_in     = speed_ff;
      force_in     = force_ff;
      dt_in        = dt_ff;
      hit_in       = hit_ff;
      hd_in        = hd_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      free_in      = free_ff;
      accel_in     = accel_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      move_in      = move_ff;
      dforce_in    = dforce_ff;
      sforce_in    = sforce_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      o_motion_in  = o_motion_ff;
      o_force_in   = o_force_ff;
      o_length_in  = o_length_ff;
      o_contact_in = o_contact_ff;

      if (cmd.load_in) begin
         dt_in  = time_step;
         hit_in = any_hit;
         hd_in  = hit_distance;
      end
      if (cmd.limit) begin
         max_in = sat32(lim_hi);
         min_in = sat32(lim_lo);
      end
      // Contact path moves straight to the limit; free path overwrites move later
      if (cmd.ground) begin
         max_in  = max_fin;
         move_in = max_fin;
         free_in = (max_fin > 32'sd0) || !hit_ff || (hd_ff > radius_ff);
      end
      if (cmd.mul_en) begin
         prod_in = mul_a * mul_b;
      end
      if (cmd.accel_latch) begin
         accel_in = (mass_ff == '0) ? 32'sd0 : sign_sat(div_quotient, force_ff[31]);
      end
      if (cmd.t1_scale) begin
         t1_in = 32'(shr_tz(prod_ff, SH_Q));
      end
      // Rescale and halve in one truncating shift
      if (cmd.t1_half) begin
         t1_in = 32'(shr_tz(prod_ff, SH_Q2));
      end
      if (cmd.t2_scale) begin
         t2_in = 32'(shr_tz(prod_ff, SH_Q));
      end
      if (cmd.move_sum) begin
         move_in = sat32(sx64(t1_ff) + sx64(t2_ff));
      end
      // Stop at the ground or the travel end
      if (cmd.move_clamp) begin
         if (move_ff > 32'sd0) begin
            if (move_ff >= max_ff) begin
               move_in = max_ff;
               free_in = 1'b0;
            end
         end else if (move_ff < min_ff) begin
            move_in = min_ff;
         end
      end
      if (cmd.speed_latch) begin
         speed_in = (dt_ff == '0) ? 32'sd0 : sign_sat(div_quotient, move_ff[31]);
      end
      if (cmd.length_update) begin
         cur_in = sat32(sx64(cur_ff) + sx64(move_ff));
      end
      // Damper force is minus the scaled product
      if (cmd.damp_scale) begin
         dforce_in = sat32(-shr_tz(prod_ff, SH_Q));
         diff_in   = sat32(signed'({33'd0, relax_ff}) - sx64(cur_ff));
      end
      if (cmd.stiff_scale) begin
         sforce_in = sat32(shr_tz(prod_ff, SH_Q));
      end
      if (cmd.force_sum) begin
         force_in = sat32(sx64(sforce_ff) + sx64(dforce_ff));
      end
      if (cmd.out_load) begin
         o_motion_in  = move_ff;
         o_force_in   = force_ff;
         o_length_in  = cur_ff;
         o_contact_in = !free_ff;
      end
   end

   // Configuration and suspension state
   always_ff @(posedge clock) begin
      if (reset) begin
         relax_ff  <= wss_pkg::RELAX_RESET;
         travel_ff <= wss_pkg::TRAVEL_RESET;
         radius_ff <= wss_pkg::RADIUS_RESET;
         mass_ff   <= wss_pkg::MASS_RESET;
         damp_ff   <= wss_pkg::DAMP_RESET;
         stiff_ff  <= wss_pkg::STIFF_RESET;
         cur_ff    <= signed'({1'b0, wss_pkg::RELAX_RESET});
         speed_ff  <= '0;
         force_ff  <= '0;
      end else begin
         relax_ff  <= relax_in;
         travel_ff <= travel_in;
         radius_ff <= radius_in;
         mass_ff   <= mass_in;
         damp_ff   <= damp_in;
         stiff_ff  <= stiff_in;
         cur_ff    <= cur_in;
         speed_ff  <= speed_in;
         force_ff  <= force_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      dt_ff        <= dt_in;
      hit_ff       <= hit_in;
      hd_ff        <= hd_in;
      max_ff       <= max_in;
      min_ff       <= min_in;
      free_ff      <= free_in;
      accel_ff     <= accel_in;
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      move_ff      <= move_in;
      dforce_ff    <= dforce_in;
      sforce_ff    <= sforce_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      o_motion_ff  <= o_motion_in;
      o_force_ff   <= o_force_in;
      o_length_ff  <= o_length_in;
      o_contact_ff <= o_contact_in;
   end

   assign status.free     = free_ff;
   assign status.div_done = div_done;

   assign rsp_tdata = {o_length_ff, o_force_ff, o_motion_ff};
   assign rsp_tuser = o_contact_ff;

endmodule

// File: sv/wss_ctrl.sv
// Step sequencer: walks the datapath through one suspension step
module wss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output wss_pkg::cmd_type    cmd,
   input  wss_pkg::status_type status
);

   typedef enum logic [20:0] {
      ST_IDLE     = 21'h00_0001,
      ST_LIMIT    = 21'h00_0002,
      ST_GROUND   = 21'h00_0004,
      ST_ACC_GO   = 21'h00_0008,
      ST_ACC_WAIT = 21'h00_0010,
      ST_MUL_ACC  = 21'h00_0020,
      ST_T1_SCALE = 21'h00_0040,
      ST_MUL_T1   = 21'h00_0080,
      ST_T1_HALF  = 21'h00_0100,
      ST_MUL_SPD  = 21'h00_0200,
      ST_T2_SCALE = 21'h00_0400,
      ST_SUM      = 21'h00_0800,
      ST_CLAMP    = 21'h00_1000,
      ST_SPD_GO   = 21'h00_2000,
      ST_SPD_WAIT = 21'h00_4000,
      ST_LENGTH   = 21'h00_8000,
      ST_DAMP     = 21'h01_0000,
      ST_MUL_STF  = 21'h02_0000,
      ST_STIFF    = 21'h04_0000,
      ST_FORCE    = 21'h08_0000,
      ST_OUT      = 21'h10_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_LIMIT;
            end
         end
         ST_LIMIT: begin
            cmd.limit = 1'b1;
            state_in  = ST_GROUND;
         end
         // Free wheel integrates the last force; otherwise go to speed
         ST_GROUND: begin
            cmd.ground = 1'b1;
            state_in   = ST_ACC_GO;
         end
         ST_ACC_GO: begin
            if (status.free) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = wss_pkg::DIV_ACCEL;
               state_in      = ST_ACC_WAIT;
            end else begin
               state_in = ST_SPD_GO;
            end
         end
         ST_ACC_WAIT: begin
            cmd.div_sel = wss_pkg::DIV_ACCEL;
            if (status.div_done) begin
               cmd.accel_latch = 1'b1;
               state_in        = ST_MUL_ACC;
            end
         end
         ST_MUL_ACC: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = wss_pkg::MUL_ACCEL;
            state_in    = ST_T1_SCALE;
         end
         ST_T1_SCALE: begin
            cmd.t1_scale = 1'b1;
            state_in     = ST_MUL_T1;
         end
         ST_MUL_T1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = wss_pkg::MUL_T1;
            state_in    = ST_T1_HALF;
         end
         ST_T1_HALF: begin
            cmd.t1_half = 1'b1;
            state_in    = ST_MUL_SPD;
         end
         ST_MUL_SPD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = wss_pkg::MUL_SPEED;
            state_in    = ST_T2_SCALE;
         end
         ST_T2_SCALE: begin
            cmd.t2_scale = 1'b1;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            cmd.move_sum = 1'b1;
            state_in     = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.move_clamp = 1'b1;
            state_in       = ST_SPD_GO;
         end
         ST_SPD_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = wss_pkg::DIV_SPEED;
            state_in      = ST_SPD_WAIT;
         end
         ST_SPD_WAIT: begin
            cmd.div_sel = wss_pkg::DIV_SPEED;
            if (status.div_done) begin
               cmd.speed_latch = 1'b1;
               state_in        = ST_LENGTH;
            end
         end
         // Length update and damper product share the cycle
         ST_LENGTH: begin
            cmd.length_update = 1'b1;
            cmd.mul_en        = 1'b1;
            cmd.mul_sel       = wss_pkg::MUL_DAMP;
            state_in          = ST_DAMP;
         end
         ST_DAMP: begin
            cmd.damp_scale = 1'b1;
            state_in       = ST_MUL_STF;
         end
         ST_MUL_STF: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = wss_pkg::MUL_STIFF;
            state_in    = ST_STIFF;
         end
         ST_STIFF: begin
            cmd.stiff_scale = 1'b1;
            state_in        = ST_FORCE;
         end
         ST_FORCE: begin
            cmd.force_sum = 1'b1;
            state_in      = ST_OUT;
         end
         // Hold until the result register is free
         ST_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register valid flag
   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: sv/wheel_suspension_step_top.sv
// Channel | Ports                             | Contents
// --------+-----------------------------------+-------------------------------------------
// req     | req_tvalid/tready/tdata/tuser     | one step request: time step, hit, distance
// rsp     | rsp_tvalid/tready/tdata/tuser     | one result: motion, force, contact, length
// csr     | csr_valid/ready/index/data        | register write, always ready
//
// From accept to loaded result, the 48-step divider runs once for acceleration
// (free wheel only) and once for the compression speed; each multiply and
// rescale is a state of its own.
// One item is worked at a time; the next is taken the cycle after its result is
// loaded, even while that result still waits in the output register.
// Reset is synchronous and active high; it restores register defaults and state.
module wheel_suspension_step_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [15:0] time_step, [46:16] hit_distance, [47] zero
   input  logic        req_tuser,   // [0] any_hit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] motion, [63:32] suspension_force,
                                    // [95:64] damper_length
   output logic        rsp_tuser,   // [0] in_contact
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_data
);

   wss_pkg::cmd_type    cmd;
   wss_pkg::status_type status;

   // Writes go straight into the configuration registers
   assign csr_ready = 1'b1;

   wss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   wss_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .time_step    (req_tdata[15:0]),
      .any_hit      (req_tuser),
      .hit_distance (req_tdata[46:16]),
      .csr_we       (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

// File: sv/wss_check.sv
// Port-level checks for the suspension step block
module wss_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic       in_acc, out_acc;
   logic [1:0] pend_ff, pend_in;

   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   // Count items taken but not yet delivered
   assign pend_in = pend_ff + 2'(in_acc) - 2'(out_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Every result belongs to an accepted item
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      out_acc |-> pend_ff != 2'd0)
      else $error("result delivered without an item outstanding");

   // An accepted item keeps the block from taking another in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      in_acc |=> !req_tready)
      else $error("item accepted while the previous one is still at work");

   // One item at work plus one waiting result at most
   a_no_third: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd2 |-> !req_tready)
      else $error("third item accepted with a result still waiting");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed or dropped");

endmodule

bind wheel_suspension_step_top wss_check u_wss_check (.*);
